### rtl/zpc_pkg.sv
package zpc_pkg;

  typedef logic signed [47:0] fx_t;
  typedef logic [46:0] ufx_t;

  localparam fx_t FX_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 48'sh8000_0000_0000;

  localparam logic [2:0] OPC_LOAD  = 3'd0;
  localparam logic [2:0] OPC_PUSH  = 3'd1;
  localparam logic [2:0] OPC_POP   = 3'd2;
  localparam logic [2:0] OPC_CLEAR = 3'd3;
  localparam logic [2:0] OPC_SET   = 3'd4;
  localparam logic [2:0] OPC_STEP  = 3'd5;

  localparam fx_t  RST_KI    = 48'sd0;
  localparam ufx_t RST_RATIO = 47'd87563216;
  localparam ufx_t RST_DT    = 47'd42949673;
  localparam ufx_t RST_DT2   = 47'd214748;
  localparam ufx_t RST_DT3   = 47'd716;

  typedef enum logic [2:0] {
    CFG_KI    = 3'd0,
    CFG_KP    = 3'd1,
    CFG_KV    = 3'd2,
    CFG_KA    = 3'd3,
    CFG_RATIO = 3'd4,
    CFG_DT    = 3'd5,
    CFG_DT2   = 3'd6,
    CFG_DT3   = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    CL_LOAD, CL_PUSH, CL_POP, CL_CLEAR, CL_SET, CL_STEP, CL_NOP
  } cls_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_READY = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FRONT_RD, S_FRONT, S_MSTART, S_MWAIT, S_PREV_RD, S_RESULT
  } state_e;

  typedef enum logic [3:0] {
    M_ZMP, M_KI, M_KP, M_KV, M_KA, M_PREV, M_P1, M_P2, M_P3, M_V1, M_V2, M_A1
  } mstep_e;

  typedef struct packed {
    cls_e       cls;
    logic [6:0] gain_index;
    fx_t        x;
    fx_t        y;
    fx_t        vx;
    fx_t        vy;
    fx_t        ax;
    fx_t        ay;
  } item_t;

  typedef struct packed {
    fx_t     pos_x;
    fx_t     vel_x;
    fx_t     acc_x;
    fx_t     pos_y;
    fx_t     vel_y;
    fx_t     acc_y;
    logic    ready;
    status_e status;
  } res_t;

  function automatic fx_t sadd(fx_t a, fx_t b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) return s[48] ? FX_MIN : FX_MAX;
    return s[47:0];
  endfunction

  function automatic fx_t ssub(fx_t a, fx_t b);
    logic signed [48:0] s;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) return s[48] ? FX_MIN : FX_MAX;
    return s[47:0];
  endfunction

endpackage

### rtl/zpc_ram.sv
module zpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/zpc_fmul.sv
module zpc_fmul import zpc_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  fx_t  a_i,
  input  fx_t  b_i,
  output logic done_o,
  output fx_t  p_o
);

  logic        busy_q;
  logic [2:0]  ph_q;
  logic        neg_q;
  logic [47:0] ua_q, ub_q;
  logic [47:0] pp_q;
  logic [1:0]  sh_q;
  logic [95:0] acc_q;
  logic        done_q;
  fx_t         p_q;

  logic [23:0] a_part, b_part;
  logic [95:0] rnd, shr, lim;
  logic [47:0] mag;

  always_comb begin
    a_part = ph_q[1] ? ua_q[47:24] : ua_q[23:0];
    b_part = ph_q[0] ? ub_q[47:24] : ub_q[23:0];
    // round half away from zero on the magnitude, then clamp
    rnd = acc_q + (96'd1 << (FRAC_BITS - 1));
    shr = rnd >> FRAC_BITS;
    lim = neg_q ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
    mag = (shr > lim) ? lim[47:0] : shr[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= 3'd0;
      end else if (busy_q) begin
        ph_q <= ph_q + 3'd1;
        if (ph_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[47] ^ b_i[47];
      ua_q  <= a_i[47] ? (~a_i + 48'd1) : a_i;
      ub_q  <= b_i[47] ? (~b_i + 48'd1) : b_i;
      acc_q <= 96'd0;
    end else if (busy_q) begin
      if (ph_q < 3'd4) begin
        pp_q <= a_part * b_part;
        sh_q <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
      end
      if (ph_q >= 3'd1 && ph_q <= 3'd4) acc_q <= acc_q + (96'(pp_q) << (24 * sh_q));
      if (ph_q == 3'd5) p_q <= neg_q ? (~mag + 48'd1) : mag;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

### rtl/zpc_front.sv
module zpc_front import zpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  gain_index_i,
  input  fx_t         in_x_i,
  input  fx_t         in_y_i,
  input  fx_t         in_vel_x_i,
  input  fx_t         in_vel_y_i,
  input  fx_t         in_acc_x_i,
  input  fx_t         in_acc_y_i,
  output logic        valid_o,
  output item_t       item_o,
  input  logic        take_i
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       acc_in;
  item_t      item_in;

  always_comb begin
    case (opcode_i)
      OPC_LOAD:  item_in.cls = CL_LOAD;
      OPC_PUSH:  item_in.cls = CL_PUSH;
      OPC_POP:   item_in.cls = CL_POP;
      OPC_CLEAR: item_in.cls = CL_CLEAR;
      OPC_SET:   item_in.cls = CL_SET;
      OPC_STEP:  item_in.cls = CL_STEP;
      default:   item_in.cls = CL_NOP;
    endcase
    item_in.gain_index = gain_index_i;
    item_in.x  = in_x_i;
    item_in.y  = in_y_i;
    item_in.vx = in_vel_x_i;
    item_in.vy = in_vel_y_i;
    item_in.ax = in_acc_x_i;
    item_in.ay = in_acc_y_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign acc_in  = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc_in) wr_q <= ~wr_q;
      if (take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc_in} - {1'b0, take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) mem_q[wr_q] <= item_in;
  end

endmodule

### rtl/zpc_back.sv
module zpc_back import zpc_pkg::*; #(
  parameter int PREVIEW_MAX = 128,
  parameter int QUEUE_DEPTH = 128,
  parameter int FRAC_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        take_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  fx_t         cfg_data_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        pop_i
);

  localparam int GA  = $clog2(PREVIEW_MAX);
  localparam int GLW = $clog2(PREVIEW_MAX + 1);
  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int XW  = 12;

  state_e         state_q, state_d;
  mstep_e         mstep_q, mstep_nx;
  logic [GLW-1:0] gl_q, i_q;
  logic [HW-1:0]  head_q, ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           started_q, axis_q, res_valid_q;
  status_e        status_q;
  fx_t            pos_q [2];
  fx_t            vel_q [2];
  fx_t            acc_q [2];
  fx_t            err_q [2];
  fx_t            ki_q, kp_q, kv_q, ka_q;
  ufx_t           ratio_q, dt_q, dt2_q, dt3_q;

  item_t          item_q;
  fx_t            front_q, u_q, t_q, np_q, nv_q;
  res_t           res_q;

  logic [XW-1:0]  gi_ext, cnt_ext, gl_ext, n_ext, tail_sum, tail, hsum, hnx, psum, pnx;
  logic           gain_ok, q_full, rdy, last, res_load;
  fx_t            p_c, v_c, a_c, e_c, q_rd, qx_rd, qy_rd, g_rd, op_a, op_b, m;
  logic           mul_start, mul_done, gain_we, q_we;
  logic [HW-1:0]  q_raddr;

  always_comb begin
    gi_ext   = XW'(item_q.gain_index);
    gain_ok  = gi_ext < XW'(PREVIEW_MAX);
    cnt_ext  = XW'(cnt_q);
    gl_ext   = XW'(gl_q);
    rdy      = (gl_q != '0) && ((cnt_ext + XW'(1)) >= gl_ext);
    n_ext    = (cnt_ext < gl_ext) ? cnt_ext : gl_ext;
    q_full   = cnt_ext == XW'(QUEUE_DEPTH);
    tail_sum = XW'(head_q) + cnt_ext;
    tail     = (tail_sum >= XW'(QUEUE_DEPTH)) ? tail_sum - XW'(QUEUE_DEPTH) : tail_sum;
    hsum     = XW'(head_q) + XW'(1);
    hnx      = (hsum >= XW'(QUEUE_DEPTH)) ? hsum - XW'(QUEUE_DEPTH) : hsum;
    psum     = XW'(ptr_q) + XW'(1);
    pnx      = (psum >= XW'(QUEUE_DEPTH)) ? psum - XW'(QUEUE_DEPTH) : psum;
    p_c      = pos_q[axis_q];
    v_c      = vel_q[axis_q];
    a_c      = acc_q[axis_q];
    e_c      = err_q[axis_q];
    q_rd     = axis_q ? qy_rd : qx_rd;
  end

  // operand selection and follow-on step of the product sequence
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mstep_nx = M_KI;
    last     = 1'b0;
    case (mstep_q)
      M_ZMP: begin op_a = fx_t'({1'b0, ratio_q}); op_b = a_c; mstep_nx = M_KI; end
      M_KI:  begin op_a = ki_q; op_b = e_c; mstep_nx = M_KP; end
      M_KP:  begin op_a = kp_q; op_b = p_c; mstep_nx = M_KV; end
      M_KV:  begin op_a = kv_q; op_b = v_c; mstep_nx = M_KA; end
      M_KA: begin
        op_a = ka_q; op_b = a_c;
        mstep_nx = (n_ext != '0) ? M_PREV : M_P1;
      end
      M_PREV: begin
        op_a = g_rd; op_b = q_rd;
        mstep_nx = ((XW'(i_q) + XW'(1)) < n_ext) ? M_PREV : M_P1;
      end
      M_P1:  begin op_a = fx_t'({1'b0, dt_q});  op_b = v_c; mstep_nx = M_P2; end
      M_P2:  begin op_a = fx_t'({1'b0, dt2_q}); op_b = a_c; mstep_nx = M_P3; end
      M_P3:  begin op_a = fx_t'({1'b0, dt3_q}); op_b = u_q; mstep_nx = M_V1; end
      M_V1:  begin op_a = fx_t'({1'b0, dt_q});  op_b = a_c; mstep_nx = M_V2; end
      M_V2:  begin op_a = fx_t'({1'b0, dt2_q}); op_b = u_q; mstep_nx = M_A1; end
      M_A1:  begin op_a = fx_t'({1'b0, dt_q});  op_b = u_q; last = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (valid_i) state_d = S_DECODE;
      S_DECODE:   state_d = (item_q.cls == CL_STEP && rdy) ? S_FRONT_RD : S_RESULT;
      S_FRONT_RD: state_d = S_FRONT;
      S_FRONT:    state_d = S_MSTART;
      S_MSTART:   state_d = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          if (last)                  state_d = axis_q ? S_RESULT : S_FRONT_RD;
          else if (mstep_nx == M_PREV) state_d = S_PREV_RD;
          else                       state_d = S_MSTART;
        end
      end
      S_PREV_RD:  state_d = S_MSTART;
      S_RESULT:   if (!res_valid_q || pop_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    take_o    = (state_q == S_IDLE) && valid_i;
    mul_start = (state_q == S_MSTART);
    gain_we   = (state_q == S_DECODE) && (item_q.cls == CL_LOAD) && gain_ok;
    q_we      = (state_q == S_DECODE) && (item_q.cls == CL_PUSH) && !q_full;
    q_raddr   = (state_q == S_FRONT_RD) ? head_q : ptr_q;
    // the result register frees as the waiting result leaves
    res_load  = (state_q == S_RESULT) && (!res_valid_q || pop_i);
  end

  zpc_ram #(.WIDTH(48), .DEPTH(PREVIEW_MAX)) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (gain_we),
    .waddr_i (gi_ext[GA-1:0]),
    .wdata_i (item_q.x),
    .raddr_i (i_q[GA-1:0]),
    .rdata_o (g_rd)
  );

  zpc_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_qx_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail[HW-1:0]),
    .wdata_i (item_q.x),
    .raddr_i (q_raddr),
    .rdata_o (qx_rd)
  );

  zpc_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_qy_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail[HW-1:0]),
    .wdata_i (item_q.y),
    .raddr_i (q_raddr),
    .rdata_o (qy_rd)
  );

  zpc_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .p_o     (m)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= M_KI;
      gl_q        <= '0;
      i_q         <= '0;
      head_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      axis_q      <= 1'b0;
      res_valid_q <= 1'b0;
      status_q    <= STS_OK;
      for (int k = 0; k < 2; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
        acc_q[k] <= '0;
        err_q[k] <= '0;
      end
      ki_q    <= RST_KI;
      kp_q    <= RST_KI;
      kv_q    <= RST_KI;
      ka_q    <= RST_KI;
      ratio_q <= RST_RATIO;
      dt_q    <= RST_DT;
      dt2_q   <= RST_DT2;
      dt3_q   <= RST_DT3;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && !cfg_index_i[3]) begin
        case (cfg_e'(cfg_index_i[2:0]))
          CFG_KI:    ki_q    <= cfg_data_i;
          CFG_KP:    kp_q    <= cfg_data_i;
          CFG_KV:    kv_q    <= cfg_data_i;
          CFG_KA:    ka_q    <= cfg_data_i;
          CFG_RATIO: ratio_q <= cfg_data_i[46:0];
          CFG_DT:    dt_q    <= cfg_data_i[46:0];
          CFG_DT2:   dt2_q   <= cfg_data_i[46:0];
          CFG_DT3:   dt3_q   <= cfg_data_i[46:0];
          default: ;
        endcase
      end
      if (res_load) res_valid_q <= 1'b1;
      else if (pop_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        S_DECODE: begin
          status_q <= STS_OK;
          axis_q   <= 1'b0;
          case (item_q.cls)
            CL_LOAD: begin
              if (gain_ok && gl_ext < gi_ext + XW'(1)) gl_q <= GLW'(gi_ext + XW'(1));
            end
            CL_PUSH: begin
              if (q_full) status_q <= STS_FULL;
              else cnt_q <= cnt_q + CW'(1);
            end
            CL_POP: begin
              if (cnt_q == '0) status_q <= STS_EMPTY;
              else begin
                head_q <= hnx[HW-1:0];
                cnt_q  <= cnt_q - CW'(1);
              end
            end
            CL_CLEAR: begin
              head_q    <= '0;
              cnt_q     <= '0;
              err_q[0]  <= '0;
              err_q[1]  <= '0;
              started_q <= 1'b0;
            end
            CL_SET: begin
              pos_q[0] <= item_q.x;
              pos_q[1] <= item_q.y;
              vel_q[0] <= item_q.vx;
              vel_q[1] <= item_q.vy;
              acc_q[0] <= item_q.ax;
              acc_q[1] <= item_q.ay;
            end
            CL_STEP: if (!rdy) status_q <= STS_NOT_READY;
            default: ;
          endcase
        end
        S_FRONT: mstep_q <= started_q ? M_ZMP : M_KI;
        S_MWAIT: begin
          if (mul_done) begin
            mstep_q <= mstep_nx;
            case (mstep_q)
              M_ZMP: err_q[axis_q] <= sadd(e_c, ssub(ssub(p_c, m), front_q));
              M_KA: begin
                i_q   <= '0;
                ptr_q <= head_q;
              end
              M_PREV: begin
                i_q   <= i_q + GLW'(1);
                ptr_q <= pnx[HW-1:0];
              end
              M_A1: begin
                pos_q[axis_q] <= np_q;
                vel_q[axis_q] <= nv_q;
                acc_q[axis_q] <= sadd(a_c, m);
                if (axis_q) started_q <= 1'b1;
                else axis_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) item_q <= item_i;
    if (state_q == S_FRONT) front_q <= (cnt_q != '0) ? q_rd : '0;
    if (state_q == S_MWAIT && mul_done) begin
      case (mstep_q)
        M_KI:   u_q  <= ssub('0, m);
        M_KP, M_KV, M_KA, M_PREV: u_q <= ssub(u_q, m);
        M_P1:   t_q  <= sadd(p_c, m);
        M_P2:   t_q  <= sadd(t_q, m);
        M_P3:   np_q <= sadd(t_q, m);
        M_V1:   t_q  <= sadd(v_c, m);
        M_V2:   nv_q <= sadd(t_q, m);
        default: ;
      endcase
    end
    if (res_load) begin
      res_q.pos_x  <= pos_q[0];
      res_q.vel_x  <= vel_q[0];
      res_q.acc_x  <= acc_q[0];
      res_q.pos_y  <= pos_q[1];
      res_q.vel_y  <= vel_q[1];
      res_q.acc_y  <= acc_q[1];
      res_q.ready  <= rdy;
      res_q.status <= status_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/zmp_preview_controller_unit.sv
// path: a non-step item goes from the input queue through the item register and the decode
// state to the result register; a control step runs n preview products, n = min(queue fill,
// gains loaded), plus a ZMP error product once a step has run, on one shared 48x48 multiplier
// flow: the back works on one item at a time and takes the next only once the last is in the
// result register; the input queue holds two and the back runs on while one result waits
// reset: asynchronous, active low; clears state and status, config to defaults, no sweep
module zmp_preview_controller_unit import zpc_pkg::*; #(
  parameter int PREVIEW_MAX = 128,
  parameter int QUEUE_DEPTH = 128,
  parameter int FRAC_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  gain_index_i,
  input  fx_t         in_x_i,
  input  fx_t         in_y_i,
  input  fx_t         in_vel_x_i,
  input  fx_t         in_vel_y_i,
  input  fx_t         in_acc_x_i,
  input  fx_t         in_acc_y_i,
  output logic        empty,
  input  logic        pop,
  output fx_t         pos_x_out_o,
  output fx_t         vel_x_out_o,
  output fx_t         acc_x_out_o,
  output fx_t         pos_y_out_o,
  output fx_t         vel_y_out_o,
  output fx_t         acc_y_out_o,
  output logic        ready_flag_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  fx_t         cfg_data_i
);

  logic  item_valid, take, res_valid;
  item_t item;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  zpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .gain_index_i (gain_index_i),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_vel_x_i   (in_vel_x_i),
    .in_vel_y_i   (in_vel_y_i),
    .in_acc_x_i   (in_acc_x_i),
    .in_acc_y_i   (in_acc_y_i),
    .valid_o      (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  zpc_back #(
    .PREVIEW_MAX (PREVIEW_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .take_o      (take),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pop_i       (pop)
  );

  assign empty        = !res_valid;
  assign pos_x_out_o  = res.pos_x;
  assign vel_x_out_o  = res.vel_x;
  assign acc_x_out_o  = res.acc_x;
  assign pos_y_out_o  = res.pos_y;
  assign vel_y_out_o  = res.vel_y;
  assign acc_y_out_o  = res.acc_y;
  assign ready_flag_o = res.ready;
  assign status_o     = res.status;

  // a waiting transaction stays on the result ports until it is taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(pos_x_out_o)))
    else $error("waiting result changed");

  a_not_ready_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STS_NOT_READY) |-> !ready_flag_o)
    else $error("not-ready status with ready flag set");

endmodule
